// File: rtl/eds_pkg.sv
// Shared types and constants for the edge DDA stepper.
`timescale 1ns / 1ps
`default_nettype none
package eds_pkg;

  localparam int XY_W    = 20;
  localparam int Z_W     = 32;
  localparam int SLOPE_W = 32;
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ROW  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SNAP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BACK = 3'd4;

  // one scan line up the page, Q12.8
  localparam logic signed [XY_W-1:0] ONE_ROW = -20'sd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_MUL_X,
    ST_MUL_Z,
    ST_MUL_END,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/eds_in_if.sv
// Command channel: valid/ready plus the edge and move fields.
`timescale 1ns / 1ps
`default_nettype none
interface eds_in_if import eds_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [XY_W-1:0]  start_x;
  logic signed [XY_W-1:0]  start_y;
  logic signed [Z_W-1:0]   start_z;
  logic signed [XY_W-1:0]  end_x;
  logic signed [XY_W-1:0]  end_y;
  logic signed [Z_W-1:0]   end_z;
  logic                    snap_on_load;
  logic signed [XY_W-1:0]  step_dy;

  modport source (output valid, cmd, start_x, start_y, start_z, end_x, end_y, end_z,
                  snap_on_load, step_dy, input ready);
  modport sink   (input valid, cmd, start_x, start_y, start_z, end_x, end_y, end_z,
                  snap_on_load, step_dy, output ready);
endinterface
`default_nettype wire

// File: rtl/eds_out_if.sv
// Result channel: valid/ready plus current point, slopes and flag.
`timescale 1ns / 1ps
`default_nettype none
interface eds_out_if import eds_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [XY_W-1:0]    cur_x;
  logic signed [XY_W-1:0]    cur_y;
  logic signed [Z_W-1:0]     cur_z;
  logic signed [SLOPE_W-1:0] slope_x;
  logic signed [SLOPE_W-1:0] slope_z;
  logic                      degenerate;

  modport source (output valid, cur_x, cur_y, cur_z, slope_x, slope_z, degenerate,
                  input ready);
  modport sink   (input valid, cur_x, cur_y, cur_z, slope_x, slope_z, degenerate,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/edge_dda_stepper.sv
// Top level of the edge DDA stepper: sequencer, shared divider and multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Edge walker for a scan-line rasterizer. One command is taken at a time; ready
// is high only while the sequencer is idle. A load runs two 32-step restoring
// divisions on one shared divider (dx/dy, then dz/dy), then a snap pass through
// the multiplier with snap_on_load; a horizontal edge skips the divisions. Moves,
// row steps and snaps go through one shared 32x20 multiplier, x then z;
// back-to-start and unused commands go straight to the result. The result sits
// in an output register, so the next command is accepted while a result waits
// to be taken.
module edge_dda_stepper import eds_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  eds_in_if.sink    req,
  eds_out_if.source rsp
);

  state_t state, state_next;

  // architectural state
  logic signed [XY_W-1:0]    origin_x, origin_y, point_x, point_y;
  logic signed [Z_W-1:0]     origin_z, point_z;
  logic signed [SLOPE_W-1:0] gradient_x, gradient_z;
  logic                      flat_edge;

  // load working registers
  logic signed [XY_W:0]  diff_x;
  logic signed [Z_W:0]   diff_z;
  logic [XY_W:0]         den_mag;
  logic                  den_neg;
  logic                  snap;
  logic                  sel_z;
  logic [XY_W:0]         rem;
  logic [31:0]           num_lo;   // numerator low bits, becomes the quotient
  logic                  big;
  logic                  neg;
  logic [4:0]            cnt;

  // move working registers
  logic signed [XY_W-1:0] mdy;
  logic signed [51:0]     prod;

  // output register
  logic                      out_valid;
  logic signed [XY_W-1:0]    out_x, out_y;
  logic signed [Z_W-1:0]     out_z;
  logic signed [SLOPE_W-1:0] out_sx, out_sz;
  logic                      out_flat;

  logic accept;
  logic out_free;
  logic in_ready;
  logic div_last;

  assign accept   = req.valid && in_ready;
  assign out_free = !out_valid || rsp.ready;
  assign div_last = (cnt == 5'd31);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (req.cmd)
            CMD_LOAD: begin
              if (req.end_y == req.start_y) begin
                state_next = req.snap_on_load ? ST_MUL_X : ST_DONE;
              end else begin
                state_next = ST_DIV_INIT;
              end
            end
            CMD_MOVE, CMD_ROW, CMD_SNAP: state_next = ST_MUL_X;
            default:                     state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (div_last) state_next = ST_DIV_DONE;
      ST_DIV_DONE: begin
        if (!sel_z)    state_next = ST_DIV_INIT;
        else if (snap) state_next = ST_MUL_X;
        else           state_next = ST_DONE;
      end
      ST_MUL_X:   state_next = ST_MUL_Z;
      ST_MUL_Z:   state_next = ST_MUL_END;
      ST_MUL_END: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign req.ready = in_ready;

  // ---------------- divider datapath ----------------
  logic signed [49:0] numer;
  logic signed [49:0] numer_abs;
  logic [16:0]        num_hi;
  logic [22:0]        trial;
  logic [31:0]        quo_pos, quo_neg, quo_res;

  always_comb begin
    numer = sel_z ? {diff_z[Z_W], diff_z, 16'h0000}
                  : {{13{diff_x[XY_W]}}, diff_x, 16'h0000};
    numer_abs = numer[49] ? -numer : numer;
    num_hi    = numer_abs[48:32];
    trial     = {1'b0, rem, num_lo[31]} - {2'b00, den_mag};
    quo_pos = (big || num_lo[31]) ? 32'h7FFF_FFFF : num_lo;
    quo_neg = (big || num_lo > 32'h8000_0000) ? 32'h8000_0000 : -num_lo;
    quo_res = neg ? quo_neg : quo_pos;
  end

  // ---------------- shared multiplier and saturating add ----------------
  logic signed [SLOPE_W-1:0] mul_a;
  logic signed [51:0]        mul_p;
  logic signed [52:0]        prod_r;
  logic signed [36:0]        step;
  logic signed [37:0]        base, sum;
  logic signed [XY_W-1:0]    x_sat;
  logic signed [Z_W-1:0]     z_sat;
  logic signed [XY_W:0]      ysum;
  logic signed [XY_W-1:0]    y_sat;

  always_comb begin
    mul_a  = (state == ST_MUL_X) ? gradient_x : gradient_z;
    mul_p  = mul_a * mdy;
    // round half up toward plus infinity, Q.24 -> Q.8
    prod_r = {prod[51], prod} + 53'sd32768;
    step   = prod_r[52:16];
    base   = (state == ST_MUL_Z) ? {{18{point_x[XY_W-1]}}, point_x}
                                 : {{6{point_z[Z_W-1]}}, point_z};
    sum    = base + {step[36], step};
    if (sum[37:19] == {19{sum[19]}}) x_sat = sum[19:0];
    else                             x_sat = sum[37] ? 20'sh80000 : 20'sh7FFFF;
    if (sum[37:31] == {7{sum[31]}})  z_sat = sum[31:0];
    else                             z_sat = sum[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    ysum = {point_y[XY_W-1], point_y} + {mdy[XY_W-1], mdy};
    if (ysum[XY_W] == ysum[XY_W-1])  y_sat = ysum[XY_W-1:0];
    else                             y_sat = ysum[XY_W] ? 20'sh80000 : 20'sh7FFFF;
  end

  // ---------------- datapath registers ----------------
  logic signed [XY_W:0] dy_load;
  assign dy_load = {req.end_y[XY_W-1], req.end_y} - {req.start_y[XY_W-1], req.start_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
      point_x    <= '0;
      point_y    <= '0;
      point_z    <= '0;
      gradient_x <= '0;
      gradient_z <= '0;
      flat_edge  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (rsp.ready)               out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority case (req.cmd)
              CMD_LOAD: begin
                origin_x <= req.start_x;
                origin_y <= req.start_y;
                origin_z <= req.start_z;
                point_x  <= req.start_x;
                point_y  <= req.start_y;
                point_z  <= req.start_z;
                diff_x   <= {req.end_x[XY_W-1], req.end_x}
                          - {req.start_x[XY_W-1], req.start_x};
                diff_z   <= {req.end_z[Z_W-1], req.end_z}
                          - {req.start_z[Z_W-1], req.start_z};
                den_neg  <= dy_load[XY_W];
                den_mag  <= dy_load[XY_W] ? -dy_load : dy_load;
                snap     <= req.snap_on_load;
                sel_z    <= 1'b0;
                mdy      <= -$signed({12'h000, req.start_y[7:0]});
                if (dy_load == '0) begin
                  gradient_x <= '0;
                  gradient_z <= '0;
                  flat_edge  <= 1'b1;
                end else begin
                  flat_edge  <= 1'b0;
                end
              end
              CMD_MOVE: mdy <= req.step_dy;
              CMD_ROW:  mdy <= ONE_ROW;
              CMD_SNAP: mdy <= -$signed({12'h000, origin_y[7:0]});
              CMD_BACK: begin
                point_x <= origin_x;
                point_y <= origin_y;
                point_z <= origin_z;
              end
              default: ;
            endcase
          end
        end
        ST_DIV_INIT: begin
          // quotient of 2^32 or more always saturates
          big    <= {4'h0, num_hi} >= den_mag;
          rem    <= {4'h0, num_hi};
          num_lo <= numer_abs[31:0];
          neg    <= numer[49] ^ den_neg;
          cnt    <= '0;
        end
        ST_DIV_STEP: begin
          if (!trial[22]) rem <= trial[XY_W:0];
          else            rem <= {rem[XY_W-1:0], num_lo[31]};
          num_lo <= {num_lo[30:0], ~trial[22]};
          cnt    <= cnt + 5'd1;
        end
        ST_DIV_DONE: begin
          if (sel_z) gradient_z <= quo_res;
          else       gradient_x <= quo_res;
          sel_z <= 1'b1;
        end
        ST_MUL_X: prod <= mul_p;
        ST_MUL_Z: begin
          point_x <= x_sat;
          prod    <= mul_p;
        end
        ST_MUL_END: begin
          point_z <= z_sat;
          point_y <= y_sat;
        end
        ST_DONE: begin
          if (out_free) begin
            out_x     <= point_x;
            out_y     <= point_y;
            out_z     <= point_z;
            out_sx    <= gradient_x;
            out_sz    <= gradient_z;
            out_flat  <= flat_edge;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cur_x      = out_x;
  assign rsp.cur_y      = out_y;
  assign rsp.cur_z      = out_z;
  assign rsp.slope_x    = out_sx;
  assign rsp.slope_z    = out_sz;
  assign rsp.degenerate = out_flat;

  // ---------------- assertions ----------------
  a_flat_zero_slopes: assert property (@(posedge clk) disable iff (rst)
    flat_edge |-> (gradient_x == '0 && gradient_z == '0))
    else $error("flat edge with nonzero slope");

  // a saturating quotient skips the remainder bound
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_STEP && !big) |-> (rem < den_mag))
    else $error("divider remainder out of range");

  a_back_to_origin: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_BACK) |=>
      (point_x == origin_x && point_y == origin_y && point_z == origin_z))
    else $error("back-to-start did not restore origin");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule
`default_nettype wire
